// ----- sv/hpt_pkg.sv -----
package hpt_pkg;

  localparam int CoordW   = 32;
  localparam int ProdW    = 64;
  localparam int SumW     = 66;
  localparam int ColW     = 51;
  localparam int DvdW     = 64;
  localparam int QuoW     = 34;
  localparam int CmpW     = ColW + QuoW;
  localparam int NumRegs  = 8;
  localparam int CfgSelW  = 3;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 64;

  localparam logic [ColW-1:0] OneQ16 = 51'h1_0000;
  localparam logic signed [ColW-1:0] ColMax = 51'sd2147483647;
  localparam logic signed [ColW-1:0] ColMin = -51'sd2147483648;
  localparam logic [CoordW-1:0] OutMax = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] OutMin = 32'h8000_0000;

  localparam logic [NumRegs-1:0][CfgDataW-1:0] CfgReset = {
    64'h0001_0000_0000_0000, 64'h0, 64'h1_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h1_0000
  };

  typedef logic [3:0][3:0][CoordW-1:0] mat_t;

  // Column results of one point, classified by w.
  typedef struct packed {
    logic [2:0][ColW-1:0] abc;
    logic [ColW-1:0]      w;
    logic                 w_zero;
    logic                 w_one;
  } col_item_t;

  // One divider stage: three lanes sharing the divisor.
  typedef struct packed {
    logic [2:0][DvdW-1:0]   rem;
    logic [2:0][QuoW-1:0]   quo;
    logic [ColW-1:0]        uw;
    logic [2:0]             neg;
    logic                   w_zero;
    logic                   w_one;
    logic [2:0][CoordW-1:0] unit_val;
    logic [2:0]             unit_sat;
  } div_stage_t;

endpackage

// ----- sv/hpt_queue.sv -----
module hpt_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] rd_data,
  output logic             empty
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]  cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CntW'(Depth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- sv/hpt_front.sv -----
module hpt_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hpt_pkg::mat_t                    mat,
  input  logic                             in_push,
  input  logic [hpt_pkg::CoordW-1:0]       in_x,
  input  logic [hpt_pkg::CoordW-1:0]       in_y,
  input  logic [hpt_pkg::CoordW-1:0]       in_z,
  output logic                             in_full,
  output logic                             q_push,
  output hpt_pkg::col_item_t               q_data,
  input  logic                             q_full
);

  logic [3:0] v_r;
  logic       adv;

  logic [2:0][hpt_pkg::CoordW-1:0]      pt_r;
  logic [2:0][3:0][hpt_pkg::ProdW-1:0]  prod_r, prod_nxt;
  logic [3:0][hpt_pkg::SumW-1:0]        sum_r, sum_nxt;
  logic [3:0][hpt_pkg::ColW-1:0]        col_r, col_nxt;

  // Stall only when a finished point cannot enter the queue.
  assign adv     = !(v_r[3] && q_full);
  assign in_full = !adv;
  assign q_push  = v_r[3] && !q_full;

  always_comb begin
    logic signed [hpt_pkg::CoordW-1:0] opa, opb;
    opa = '0;
    opb = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        opa = pt_r[r];
        opb = mat[r][c];
        prod_nxt[r][c] = opa * opb;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_nxt[c] = {{2{prod_r[0][c][hpt_pkg::ProdW-1]}}, prod_r[0][c]}
                 + {{2{prod_r[1][c][hpt_pkg::ProdW-1]}}, prod_r[1][c]}
                 + {{2{prod_r[2][c][hpt_pkg::ProdW-1]}}, prod_r[2][c]};
      col_nxt[c] = {sum_r[c][hpt_pkg::SumW-1], sum_r[c][hpt_pkg::SumW-1:16]}
                 + {{(hpt_pkg::ColW - hpt_pkg::CoordW){mat[3][c][hpt_pkg::CoordW-1]}},
                    mat[3][c]};
    end
  end

  always_comb begin
    q_data.abc    = col_r[2:0];
    q_data.w      = col_r[3];
    q_data.w_zero = (col_r[3] == '0);
    q_data.w_one  = (col_r[3] == hpt_pkg::OneQ16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[2:0], in_push};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt_r   <= {in_z, in_y, in_x};
      prod_r <= prod_nxt;
      sum_r  <= sum_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

// ----- sv/hpt_back.sv -----
module hpt_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  hpt_pkg::col_item_t         q_data,
  output logic                       q_pop,
  input  logic                       out_pop,
  output logic                       out_empty,
  output logic [hpt_pkg::CoordW-1:0] out_x,
  output logic [hpt_pkg::CoordW-1:0] out_y,
  output logic [hpt_pkg::CoordW-1:0] out_z,
  output logic                       out_w_zero,
  output logic                       out_saturated
);

  localparam int QuoW = hpt_pkg::QuoW;
  localparam int ColW = hpt_pkg::ColW;

  logic                 adv;
  logic [QuoW:0]        v_r;
  hpt_pkg::div_stage_t  st_r [QuoW+1];
  hpt_pkg::div_stage_t  st_nxt [QuoW+1];

  logic                                 out_v_r;
  logic [2:0][hpt_pkg::CoordW-1:0]      res_r, res_nxt;
  logic                                 wz_r, sat_r, sat_nxt;

  assign adv   = !out_v_r || out_pop;
  assign q_pop = adv && !q_empty;

  // Entry stage: magnitudes, signs, dividends and the unit-w clamp.
  always_comb begin
    logic [ColW-1:0] a;
    st_nxt[0] = '0;
    st_nxt[0].uw     = q_data.w[ColW-1] ? ColW'(0) - q_data.w : q_data.w;
    st_nxt[0].w_zero = q_data.w_zero;
    st_nxt[0].w_one  = q_data.w_one;
    for (int k = 0; k < 3; k++) begin
      a = q_data.abc[k];
      st_nxt[0].neg[k] = a[ColW-1] ^ q_data.w[ColW-1];
      st_nxt[0].rem[k] = hpt_pkg::DvdW'({(a[ColW-1] ? ColW'(0) - a : a), 16'h0});
      if ($signed(a) > hpt_pkg::ColMax) begin
        st_nxt[0].unit_val[k] = hpt_pkg::OutMax;
        st_nxt[0].unit_sat[k] = 1'b1;
      end else if ($signed(a) < hpt_pkg::ColMin) begin
        st_nxt[0].unit_val[k] = hpt_pkg::OutMin;
        st_nxt[0].unit_sat[k] = 1'b1;
      end else begin
        st_nxt[0].unit_val[k] = a[hpt_pkg::CoordW-1:0];
      end
    end
  end

  // One quotient bit per stage, top bit first; the top bit marks overflow.
  for (genvar s = 0; s < QuoW; s++) begin : g_div
    localparam int Bit = QuoW - 1 - s;
    always_comb begin
      logic [hpt_pkg::CmpW-1:0] sh;
      st_nxt[s+1] = st_r[s];
      sh = hpt_pkg::CmpW'(st_r[s].uw) << Bit;
      for (int k = 0; k < 3; k++) begin
        if (hpt_pkg::CmpW'(st_r[s].rem[k]) >= sh) begin
          st_nxt[s+1].rem[k]      = st_r[s].rem[k] - sh[hpt_pkg::DvdW-1:0];
          st_nxt[s+1].quo[k][Bit] = 1'b1;
        end
      end
    end
  end

  // Final selection and clamp.
  always_comb begin
    logic [QuoW-1:0] q;
    logic [QuoW-1:0] nq;
    sat_nxt = 1'b0;
    q  = '0;
    nq = '0;
    for (int k = 0; k < 3; k++) begin
      q  = st_r[QuoW].quo[k];
      nq = QuoW'(0) - q;
      if (st_r[QuoW].w_zero) begin
        res_nxt[k] = '0;
      end else if (st_r[QuoW].w_one) begin
        res_nxt[k] = st_r[QuoW].unit_val[k];
        sat_nxt    = sat_nxt | st_r[QuoW].unit_sat[k];
      end else if (st_r[QuoW].neg[k]) begin
        if (q[QuoW-1] || (q[QuoW-2:0] > 33'h0_8000_0000)) begin
          res_nxt[k] = hpt_pkg::OutMin;
          sat_nxt    = 1'b1;
        end else begin
          res_nxt[k] = nq[hpt_pkg::CoordW-1:0];
        end
      end else begin
        if (q[QuoW-1:31] != '0) begin
          res_nxt[k] = hpt_pkg::OutMax;
          sat_nxt    = 1'b1;
        end else begin
          res_nxt[k] = q[hpt_pkg::CoordW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v_r     <= {v_r[QuoW-1:0], q_pop};
      out_v_r <= v_r[QuoW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s <= QuoW; s++) begin
        st_r[s] <= st_nxt[s];
      end
      res_r <= res_nxt;
      wz_r  <= st_r[QuoW].w_zero;
      sat_r <= sat_nxt;
    end
  end

  assign out_empty     = !out_v_r;
  assign out_x         = res_r[0];
  assign out_y         = res_r[1];
  assign out_z         = res_r[2];
  assign out_w_zero    = wz_r;
  assign out_saturated = sat_r;

endmodule

// ----- sv/homogeneous_point_transform_unit.sv -----
// An accepted item passes the front end, the center queue, the divider and the output register.
// Throughput: one item per cycle unless stalled; the 4-stage front end and 35-stage divider are
// fully pipelined. A held result stalls the back end; a full center queue stalls the front end.
// Reset (rst_n, synchronous, active low) empties all pipelines and the queue and loads
// the identity matrix into the configuration registers.
module homogeneous_point_transform_unit #(
  parameter int QueueDepth = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic [hpt_pkg::CoordW-1:0]   in_x,
  input  logic [hpt_pkg::CoordW-1:0]   in_y,
  input  logic [hpt_pkg::CoordW-1:0]   in_z,
  output logic                         in_full,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic [hpt_pkg::CoordW-1:0]   out_x,
  output logic [hpt_pkg::CoordW-1:0]   out_y,
  output logic [hpt_pkg::CoordW-1:0]   out_z,
  output logic                         out_w_zero,
  output logic                         out_saturated,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hpt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [hpt_pkg::CfgDataW-1:0] cfg_data
);

  logic [hpt_pkg::NumRegs-1:0][hpt_pkg::CfgDataW-1:0] cfg_r;
  hpt_pkg::mat_t      mat;
  hpt_pkg::col_item_t q_wdata, q_rdata;
  logic               q_push, q_full, q_pop, q_empty;

  // Configuration writes are always taken; drop indexes past the register list.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= hpt_pkg::CfgReset;
    end else if (cfg_valid && (cfg_index < hpt_pkg::CfgIdxW'(hpt_pkg::NumRegs))) begin
      cfg_r[cfg_index[hpt_pkg::CfgSelW-1:0]] <= cfg_data;
    end
  end

  // Unpack the matrix: two columns per register, even column in the low half.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = cfg_r[2*r + c/2][32*(c%2) +: 32];
      end
    end
  end

  // Front end: capture the point, form the four column sums, classify w.
  hpt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .mat     (mat),
    .in_push (in_push),
    .in_x    (in_x),
    .in_y    (in_y),
    .in_z    (in_z),
    .in_full (in_full),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  // Short queue decouples the front stall from the back stall.
  hpt_queue #(
    .Width ($bits(hpt_pkg::col_item_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // Back end: pipelined divide by w, clamp, and hold the result for pop.
  hpt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w_zero    (out_w_zero),
    .out_saturated (out_saturated)
  );

endmodule

// ----- dv/tb_homogeneous_point_transform_unit.sv -----
`timescale 1ns / 1ps

module tb_homogeneous_point_transform_unit;

  // Matrix register indexes, in register order.
  typedef enum logic [hpt_pkg::CfgIdxW-1:0] {
    RegRow0C01, RegRow0C23, RegRow1C01, RegRow1C23,
    RegRow2C01, RegRow2C23, RegRow3C01, RegRow3C23
  } mat_reg_e;

  typedef struct {
    logic [hpt_pkg::CoordW-1:0] x;
    logic [hpt_pkg::CoordW-1:0] y;
    logic [hpt_pkg::CoordW-1:0] z;
    logic              w_zero;
    logic              sat;
  } xform_t;

  localparam logic [31:0] QOne  = 32'h0001_0000;
  localparam logic [31:0] QHalf = 32'h0000_8000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic [hpt_pkg::CoordW-1:0] in_x = '0, in_y = '0, in_z = '0;
  logic in_full;
  logic out_pop = 1'b0;
  logic out_empty;
  logic [hpt_pkg::CoordW-1:0] out_x, out_y, out_z;
  logic out_w_zero, out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hpt_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [hpt_pkg::CfgDataW-1:0] cfg_data = '0;

  // Shadow copy of the matrix registers.
  logic [hpt_pkg::CfgDataW-1:0] mat_regs [hpt_pkg::NumRegs];
  xform_t expected_pts[$];
  int mismatches = 0;
  // Set to hold both sides free of idle cycles.
  bit steady_flow = 1'b0;

  homogeneous_point_transform_unit u_dut (.*);

  always #6 clk = ~clk;

  // Signed Q16.16 matrix entry M[r][c], widened.
  function automatic logic signed [79:0] entry(int r, int c);
    logic [63:0] rv;
    rv = mat_regs[r * 2 + c / 2];
    return (c % 2) ? $signed(rv[63:32]) : $signed(rv[31:0]);
  endfunction

  // Transform one point: row vector times matrix, then perspective divide.
  function automatic xform_t transform_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic signed [79:0] p [3];
    logic signed [79:0] col [4];
    logic signed [79:0] sum;
    logic [79:0] ua, uw, q;
    logic [31:0] res [3];
    logic neg;
    xform_t r;
    p[0] = $signed(x);
    p[1] = $signed(y);
    p[2] = $signed(z);
    for (int k = 0; k < 4; k++) begin
      sum = p[0] * entry(0, k) + p[1] * entry(1, k) + p[2] * entry(2, k);
      col[k] = (sum >>> 16) + entry(3, k);
    end
    r.sat = 1'b0;
    r.w_zero = (col[3] == 0);
    for (int k = 0; k < 3; k++) begin
      if (r.w_zero) begin
        res[k] = '0;
      end else if (col[3] == 80'sh1_0000) begin
        // Unit w: pass through, clamped.
        if (col[k] > 80'sd2147483647) begin
          res[k] = 32'h7FFF_FFFF;
          r.sat = 1'b1;
        end else if (col[k] < -80'sd2147483648) begin
          res[k] = 32'h8000_0000;
          r.sat = 1'b1;
        end else begin
          res[k] = col[k][31:0];
        end
      end else begin
        // Divide magnitudes, truncate toward zero, then clamp.
        neg = col[k][79] ^ col[3][79];
        ua = col[k][79] ? -col[k] : col[k];
        uw = col[3][79] ? -col[3] : col[3];
        q = (ua << 16) / uw;
        if (neg) begin
          if (q > 80'h8000_0000) begin
            res[k] = 32'h8000_0000;
            r.sat = 1'b1;
          end else begin
            res[k] = 32'(-q);
          end
        end else if (q > 80'h7FFF_FFFF) begin
          res[k] = 32'h7FFF_FFFF;
          r.sat = 1'b1;
        end else begin
          res[k] = q[31:0];
        end
      end
    end
    r.x = res[0];
    r.y = res[1];
    r.z = res[2];
    return r;
  endfunction

  // Send one point; predict it at the edge that accepts it. Leave in_push high.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (!steady_flow && $urandom_range(99) < 7) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    @(negedge clk);
    while (in_full) @(negedge clk);
    @(posedge clk);
    expected_pts.push_back(transform_point(x, y, z));
  endtask

  // Drop push and hold until every expected item has come out.
  task automatic drain();
    in_push <= 1'b0;
    while (expected_pts.size() != 0) @(posedge clk);
  endtask

  // Write one register; lower valid only after the last of a batch.
  task automatic cfg_write(logic [hpt_pkg::CfgIdxW-1:0] idx, logic [63:0] data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (idx < hpt_pkg::NumRegs) mat_regs[idx] = data;
    if (last) cfg_valid <= 1'b0;
  endtask

  // Load a full matrix given as M[r][c] entries.
  task automatic load_matrix(logic [3:0][3:0][31:0] m);
    drain();
    for (int i = 0; i < hpt_pkg::NumRegs; i++)
      cfg_write(mat_reg_e'(i), {m[i / 2][(i % 2) * 2 + 1], m[i / 2][(i % 2) * 2]},
                i == hpt_pkg::NumRegs - 1);
  endtask

  function automatic logic [3:0][3:0][31:0] diag(logic [31:0] s, logic [31:0] m33);
    logic [3:0][3:0][31:0] m;
    m = '0;
    m[0][0] = s;
    m[1][1] = s;
    m[2][2] = s;
    m[3][3] = m33;
    return m;
  endfunction

  // Coordinate or entry with a bias toward edges and small magnitudes.
  function automatic logic [31:0] rand_q16();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
      2: return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
      3: begin
        case ($urandom_range(5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return QOne;
          3: return -QOne;
          4: return 32'hFFFF_FFFF;
          default: return '0;
        endcase
      end
      default: return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
    endcase
  endfunction

  // Pull results with random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= steady_flow || ($urandom_range(99) >= 7);
    end
  end

  // Compare each popped item; outputs are stable at the falling edge before acceptance.
  always @(negedge clk) begin
    xform_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item x=%h y=%h z=%h", out_x, out_y, out_z);
      end else begin
        e = expected_pts.pop_front();
        if (out_x !== e.x || out_y !== e.y || out_z !== e.z ||
            out_w_zero !== e.w_zero || out_saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h wz=%b sat=%b got %h %h %h wz=%b sat=%b",
                     e.x, e.y, e.z, e.w_zero, e.sat,
                     out_x, out_y, out_z, out_w_zero, out_saturated);
        end
      end
    end
  end

  // Identity after reset: extremes pass through untouched.
  task automatic test_identity();
    send_point('0, '0, '0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, QOne);
    send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001);
  endtask

  // Scale by 2 with unit w: clamp on both sides.
  task automatic test_unit_clamp();
    load_matrix(diag(32'h0002_0000, QOne));
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
    send_point(32'h3FFF_FFFF, 32'hC000_0000, 32'hFFFF_FFFF);
    send_point(32'h4000_0000, 32'hBFFF_FFFF, '0);
  endtask

  // w taken from z: zero w, unit w, general w, quotient at and past the limits.
  task automatic test_perspective();
    logic [3:0][3:0][31:0] m;
    m = diag(QOne, '0);
    m[2][3] = QOne;
    load_matrix(m);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_point(32'h0001_2345, 32'hFFFE_0000, QOne);
    send_point(32'hC000_0000, 32'h4000_0000, QHalf);
    send_point(32'h4000_0000, 32'hC000_0000, -QHalf);
    send_point(32'h0003_0000, 32'hFFFD_0000, 32'h0002_0000);
    send_point(32'h7FFF_FFFF, 32'h0000_0007, 32'h0000_0001);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
    send_point(32'h0000_0003, 32'hFFFF_FFFD, 32'hFFFE_0000);
  endtask

  // Writes to indexes past the last register change nothing.
  task automatic test_bad_index();
    load_matrix(diag(QOne, QOne));
    // Let valid drop for a cycle before the next batch.
    @(posedge clk);
    for (int k = 0; k < 2 ** hpt_pkg::CfgIdxW - hpt_pkg::NumRegs; k++)
      cfg_write(hpt_pkg::CfgIdxW'(hpt_pkg::NumRegs + k), {$urandom(), $urandom()},
                k == 2 ** hpt_pkg::CfgIdxW - hpt_pkg::NumRegs - 1);
    send_point(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'hFFFF_0000, 32'h0000_ABCD, 32'h1111_0000);
  endtask

  // Random matrices, each followed by a burst of random points.
  task automatic test_random();
    logic [3:0][3:0][31:0] m;
    for (int ph = 0; ph < 11; ph++) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          m[r][c] = rand_q16();
      // Keep w at one in some phases so the pass-through path sees random data.
      if (ph % 3 == 0) begin
        m[0][3] = '0;
        m[1][3] = '0;
        m[2][3] = '0;
        m[3][3] = QOne;
      end
      if (ph == 10) m = '1;
      load_matrix(m);
      steady_flow = (ph == 5);
      repeat (150) send_point(rand_q16(), rand_q16(), rand_q16());
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < hpt_pkg::NumRegs; i++) mat_regs[i] = hpt_pkg::CfgReset[i];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity();
    test_unit_clamp();
    test_perspective();
    test_bad_index();
    test_random();
    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_pts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
